// ===== sv/grouped_charbonnier_smooth_weight_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GROUPED_CHARBONNIER_SMOOTH_WEIGHT_DEFINES_SVH
`define GROUPED_CHARBONNIER_SMOOTH_WEIGHT_DEFINES_SVH

// Overlapping implication, checked outside reset.
`define GCSW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gcsw check failed");

// Implication into the next cycle, checked outside reset.
`define GCSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gcsw check failed");

`endif

// ===== sv/gcsw_pkg.sv =====
`default_nettype none
package gcsw_pkg;
    localparam int NTERM      = 9;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 24;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 35;
    localparam int DIV_STEPS  = 47;
    localparam int SQRT_STEPS = 24;
    localparam int FRONT      = 3;
    localparam int LAT        = FRONT + DIV_STEPS + SQRT_STEPS;

    localparam logic [2:0] MODE_COMP   = 3'd0;
    localparam logic [2:0] MODE_DIR    = 3'd1;
    localparam logic [2:0] MODE_SPLIT  = 3'd2;
    localparam logic [2:0] MODE_ALL    = 3'd3;
    localparam logic [2:0] MODE_ST     = 3'd4;
    // Each term alone; the three codes behave the same.
    localparam logic [2:0] MODE_EACH   = 3'd5;
    localparam logic [2:0] MODE_EACH_B = 3'd6;
    localparam logic [2:0] MODE_EACH_C = 3'd7;

    localparam logic REG_EPS  = 1'b0;
    localparam logic REG_MODE = 1'b1;
endpackage
`default_nettype wire

// ===== sv/grouped_charbonnier_smooth_weight.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: ux uy ut vx vy vt wx wy wt, 16 b each
// m_        out        m_tvalid/m_tready  m_tdata: weight_ux .. weight_wt, 24 b each
// cfg_      in         cfg_valid/cfg_ready cfg_index (0 eps, 1 group_mode), cfg_data
//
// One voxel enters per cycle while m_ is not stalled; each request passes
// three front stages (squares, partial sums, group sum), 47 divider stages
// and 24 square-root stages, one bit each. aresetn is synchronous, active low,
// and clears the valid chain and the registers. A stall on m_ freezes the
// whole pipeline; s_tready follows the output side combinationally.
`default_nettype none
module grouped_charbonnier_smooth_weight (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [143:0]  s_tdata,   // ux, uy, ut, vx, vy, vt, wx, wy, wt
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [215:0]  m_tdata,   // weight_ux .. weight_wt, same order
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import gcsw_pkg::*;

    logic [15:0] eps_reg;
    logic [2:0]  mode_reg;
    logic [LAT-1:0] vld_reg;
    logic        en;

    logic [SQ_W-1:0] sq1_reg [0:NTERM-1];
    logic [31:0]     e2_1_reg;
    logic [2:0]      mode1_reg;

    logic [SQ_W-1:0] sq2_reg [0:NTERM-1];
    logic [31:0]     row_reg [0:2];
    logic [31:0]     pair_reg [0:2];
    logic [31:0]     col_reg [0:2];
    logic [31:0]     e2_2_reg;
    logic [2:0]      mode2_reg;

    logic [SUM_W-1:0] sum_reg [0:NTERM-1];
    logic             zero_reg [0:NTERM-1];

    logic [33:0] all_sum;
    logic [33:0] sp_sum;

    // Advance the pipeline whenever the output register is free or drains.
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    // Registers: eps and group mode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg  <= 16'd256;
            mode_reg <= MODE_COMP;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_EPS:  eps_reg  <= cfg_data;
                REG_MODE: mode_reg <= cfg_data[2:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Stage 1: square each derivative by its magnitude.
    for (genvar i = 0; i < NTERM; i++) begin : g_sq
        logic [IN_W-1:0] d;
        logic [IN_W-1:0] mag;
        logic [31:0]     p;
        assign d   = s_tdata[i*IN_W +: IN_W];
        assign mag = d[IN_W-1] ? (~d + 16'd1) : d;
        assign p   = 32'(mag) * 32'(mag);
        always_ff @(posedge aclk) begin
            if (en) sq1_reg[i] <= p[SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e2_1_reg  <= 32'(eps_reg) * 32'(eps_reg);
            mode1_reg <= mode_reg;
        end
    end

    // Stage 2: row, spatial-pair and column sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                row_reg[c]  <= 32'(sq1_reg[3*c]) + 32'(sq1_reg[3*c+1]) + 32'(sq1_reg[3*c+2]);
                pair_reg[c] <= 32'(sq1_reg[3*c]) + 32'(sq1_reg[3*c+1]);
                col_reg[c]  <= 32'(sq1_reg[c]) + 32'(sq1_reg[3+c]) + 32'(sq1_reg[6+c]);
            end
            for (int i = 0; i < NTERM; i++) sq2_reg[i] <= sq1_reg[i];
            e2_2_reg  <= e2_1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    assign all_sum = 34'(row_reg[0]) + 34'(row_reg[1]) + 34'(row_reg[2]);
    assign sp_sum  = 34'(pair_reg[0]) + 34'(pair_reg[1]) + 34'(pair_reg[2]);

    // Stage 3: pick each term's group sum and add eps squared.
    for (genvar i = 0; i < NTERM; i++) begin : g_grp
        logic [33:0]      grp;
        logic [SUM_W-1:0] s;
        always_comb begin
            case (mode2_reg)
                MODE_COMP:  grp = 34'(row_reg[i/3]);
                MODE_DIR:   grp = 34'(col_reg[i%3]);
                MODE_SPLIT: grp = (i%3 != 2) ? 34'(pair_reg[i/3]) : 34'(sq2_reg[i]);
                MODE_ALL:   grp = all_sum;
                MODE_ST:    grp = (i%3 != 2) ? sp_sum : 34'(col_reg[2]);
                default:    grp = 34'(sq2_reg[i]);
            endcase
        end
        assign s = SUM_W'(grp) + SUM_W'(e2_2_reg);
        always_ff @(posedge aclk) begin
            if (en) begin
                sum_reg[i]  <= s;
                zero_reg[i] <= (s == '0);
            end
        end

        // Divide and root: weight = isqrt(floor(2^46 / S)).
        gcsw_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .s_sum  (sum_reg[i]),
            .s_zero (zero_reg[i]),
            .weight (m_tdata[i*OUT_W +: OUT_W])
        );
    end
endmodule
`default_nettype wire

// ===== sv/gcsw_lane.sv =====
`default_nettype none
module gcsw_lane (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [gcsw_pkg::SUM_W-1:0] s_sum,
    input  wire logic                       s_zero,
    output logic      [gcsw_pkg::OUT_W-1:0] weight
);
    import gcsw_pkg::*;

    logic [SUM_W:0]     dr_reg [0:DIV_STEPS-1];
    logic [SUM_W-1:0]   ds_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] dq_reg [0:DIV_STEPS-1];
    logic               dz_reg [0:DIV_STEPS-1];

    logic [2*SQRT_STEPS-1:0] sx_reg [0:SQRT_STEPS-1];
    logic [OUT_W+1:0]   srem_reg [0:SQRT_STEPS-1];
    logic [OUT_W-1:0]   sroot_reg [0:SQRT_STEPS-1];
    logic               sz_reg [0:SQRT_STEPS-1];

    // Restoring division of 2^46 by the sum, one quotient bit per stage.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [SUM_W:0]       r_in;
        logic [SUM_W-1:0]     s_in;
        logic [DIV_STEPS-1:0] q_in;
        logic                 z_in;
        logic [SUM_W:0]       t;
        if (k == 0) begin : g_first
            assign r_in = '0;
            assign s_in = s_sum;
            assign q_in = '0;
            assign z_in = s_zero;
        end else begin : g_rest
            assign r_in = dr_reg[k-1];
            assign s_in = ds_reg[k-1];
            assign q_in = dq_reg[k-1];
            assign z_in = dz_reg[k-1];
        end
        assign t = {r_in[SUM_W-1:0], 1'(k == 0)};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (t >= {1'b0, s_in}) begin
                    dr_reg[k] <= t - {1'b0, s_in};
                    dq_reg[k] <= {q_in[DIV_STEPS-2:0], 1'b1};
                end else begin
                    dr_reg[k] <= t;
                    dq_reg[k] <= {q_in[DIV_STEPS-2:0], 1'b0};
                end
                ds_reg[k] <= s_in;
                dz_reg[k] <= z_in;
            end
        end
    end

    // Integer square root of the quotient, one root bit per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [2*SQRT_STEPS-1:0] x_in;
        logic [OUT_W+1:0]        rem_in;
        logic [OUT_W-1:0]        root_in;
        logic                    z_in;
        logic [OUT_W+3:0]        sh;
        logic [OUT_W+3:0]        trial;
        if (j == 0) begin : g_first
            assign x_in    = {1'b0, dq_reg[DIV_STEPS-1]};
            assign rem_in  = '0;
            assign root_in = '0;
            assign z_in    = dz_reg[DIV_STEPS-1];
        end else begin : g_rest
            assign x_in    = sx_reg[j-1];
            assign rem_in  = srem_reg[j-1];
            assign root_in = sroot_reg[j-1];
            assign z_in    = sz_reg[j-1];
        end
        assign sh    = {rem_in, x_in[2*SQRT_STEPS-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sh >= trial) begin
                    srem_reg[j]  <= (OUT_W+2)'(sh - trial);
                    sroot_reg[j] <= {root_in[OUT_W-2:0], 1'b1};
                end else begin
                    srem_reg[j]  <= sh[OUT_W+1:0];
                    sroot_reg[j] <= {root_in[OUT_W-2:0], 1'b0};
                end
                sx_reg[j] <= {x_in[2*SQRT_STEPS-3:0], 2'b00};
                sz_reg[j] <= z_in;
            end
        end
    end

    // A zero denominator saturates the weight.
    assign weight = sz_reg[SQRT_STEPS-1] ? '1 : sroot_reg[SQRT_STEPS-1];
endmodule
`default_nettype wire

// ===== sv/gcsw_checker.sv =====
`default_nettype none
`include "grouped_charbonnier_smooth_weight_defines.svh"
module gcsw_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [215:0] m_tdata,
    input wire logic         cfg_ready
);
    `GCSW_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `GCSW_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
    `GCSW_ASSERT_NOW(a_ready_follows, 1'b1, s_tready == (!m_tvalid || m_tready))
    `GCSW_ASSERT_NOW(a_cfg_open, 1'b1, cfg_ready)
    `GCSW_ASSERT_NOW(a_empty_after_reset, $rose(aresetn), !m_tvalid)
endmodule

bind grouped_charbonnier_smooth_weight gcsw_checker u_gcsw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
    import gcsw_pkg::*;

    // Scoreboard: keeps its own copy of the block's registers, predicts the
    // nine weights of every accepted voxel and compares them in order.
    class weight_scoreboard;
        logic [15:0]  eps_q8;
        logic [2:0]   mode;
        logic [215:0] pending_weights[$];
        int           errors;
        int           checked;

        function new();
            eps_q8 = 16'd256;
            mode = MODE_COMP;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == REG_EPS) eps_q8 = value;
            else mode = value[2:0];
        endfunction

        // Largest r with r*r <= x.
        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // floor(0.5 / sqrt(total)) in Q8.16, saturating.
        function logic [23:0] robust_weight(longint unsigned total);
            longint unsigned w;
            if (total == 0) return 24'hFFFFFF;
            w = int_sqrt((64'd1 << 46) / total);
            return (w > 64'hFFFFFF) ? 24'hFFFFFF : w[23:0];
        endfunction

        function void note_voxel(logic [143:0] voxel);
            longint unsigned sq[9];
            longint unsigned grp[9];
            longint unsigned e2, s, t;
            longint mag;
            logic signed [15:0] d;
            logic [215:0] w;
            for (int i = 0; i < 9; i++) begin
                d = voxel[16*i +: 16];
                mag = (d < 0) ? -longint'(d) : longint'(d);
                sq[i] = mag * mag;
                grp[i] = sq[i];
            end
            e2 = longint'(eps_q8) * longint'(eps_q8);
            case (mode)
                MODE_COMP: begin
                    for (int c = 0; c < 3; c++) begin
                        s = sq[3*c] + sq[3*c+1] + sq[3*c+2];
                        for (int k = 0; k < 3; k++) grp[3*c+k] = s;
                    end
                end
                MODE_DIR: begin
                    for (int k = 0; k < 3; k++) begin
                        s = sq[k] + sq[3+k] + sq[6+k];
                        for (int c = 0; c < 3; c++) grp[3*c+k] = s;
                    end
                end
                MODE_SPLIT: begin
                    for (int c = 0; c < 3; c++) begin
                        s = sq[3*c] + sq[3*c+1];
                        grp[3*c] = s;
                        grp[3*c+1] = s;
                    end
                end
                MODE_ALL: begin
                    s = 0;
                    for (int i = 0; i < 9; i++) s += sq[i];
                    for (int i = 0; i < 9; i++) grp[i] = s;
                end
                MODE_ST: begin
                    s = 0;
                    t = 0;
                    for (int c = 0; c < 3; c++) begin
                        s += sq[3*c] + sq[3*c+1];
                        t += sq[3*c+2];
                    end
                    for (int c = 0; c < 3; c++) begin
                        grp[3*c] = s;
                        grp[3*c+1] = s;
                        grp[3*c+2] = t;
                    end
                end
                default: ; // each term alone
            endcase
            for (int i = 0; i < 9; i++) w[24*i +: 24] = robust_weight(e2 + grp[i]);
            pending_weights.push_back(w);
        endfunction

        function void check_weights(logic [215:0] got);
            logic [215:0] exp_w;
            if (pending_weights.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending_weights.pop_front();
            checked++;
            for (int i = 0; i < 9; i++)
                if (got[24*i +: 24] !== exp_w[24*i +: 24]) begin
                    $display("%0t: weight %0d mismatch, expected %h actual %h",
                             $time, i, exp_w[24*i +: 24], got[24*i +: 24]);
                    errors++;
                end
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [143:0]  s_tdata = '0;    // ux, uy, ut, vx, vy, vt, wx, wy, wt
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [215:0]  m_tdata;         // weight_ux .. weight_wt
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_index = 1'b0;
    logic [15:0]   cfg_data = '0;

    // Set during a stretch where neither side idles.
    bit            no_gaps = 0;
    int            voxels_sent = 0;
    weight_scoreboard sb = new();

    grouped_charbonnier_smooth_weight u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Monitor both channels at the edge, before any driver update lands.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_voxel(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_weights(m_tdata);
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Randomly stall the result side.
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            n = no_gaps ? 1 : $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
            n = gap_len();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Drop valid after the write and let the bus idle before returning.
    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    // Hold the request until accepted; valid stays high for the caller unless a gap follows.
    task automatic send_voxel(logic [143:0] voxel);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= voxel;
        do @(posedge aclk); while (!s_tready);
        voxels_sent++;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Wait until every weight is back, then let the pipeline empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_weights.size() != 0) @(posedge aclk);
        repeat (LAT + 8) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_deriv();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3, 4: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] rand_voxel();
        logic [143:0] v;
        for (int i = 0; i < 9; i++) v[16*i +: 16] = rand_deriv();
        return v;
    endfunction

    function automatic logic [143:0] fill_voxel(logic [15:0] d);
        logic [143:0] v;
        for (int i = 0; i < 9; i++) v[16*i +: 16] = d;
        return v;
    endfunction

    initial begin
        logic [15:0] eps_list[10] = '{16'd1, 16'd65535, 16'd256, 16'd1, 16'd65535,
                                      16'd300, 16'd1, 16'd4096, 16'd65535, 16'd0};
        logic [2:0]  mode_list[10] = '{MODE_ALL, MODE_COMP, MODE_DIR, MODE_SPLIT,
                                       MODE_ST, MODE_EACH, MODE_EACH_B, MODE_EACH_C,
                                       MODE_ALL, MODE_COMP};
        logic [143:0] v;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: eps 1.0, per component.
        send_voxel(fill_voxel(16'h0000));
        send_voxel(fill_voxel(16'h0100));
        drain();

        // Directed: smallest nonzero eps, all terms grouped; zero voxel gives the largest weight.
        write_reg(REG_EPS, 16'd1);
        write_reg(REG_MODE, MODE_ALL);
        send_voxel(fill_voxel(16'h0000));
        send_voxel(fill_voxel(16'h7FFF));
        send_voxel(fill_voxel(16'h8000));
        send_voxel(fill_voxel(16'hFFFF));
        send_voxel(fill_voxel(16'h0001));
        for (int i = 0; i < 9; i++) begin
            v = '0;
            v[16*i +: 16] = (i % 2) ? 16'h8000 : 16'h7FFF;
            send_voxel(v);
        end
        drain();
        write_reg(REG_MODE, MODE_EACH);
        send_voxel(fill_voxel(16'h0000));
        send_voxel(fill_voxel(16'h8000));
        drain();

        // Random phases over register settings, one stretch without gaps.
        eps_list[9] = 16'($urandom_range(1, 65535));
        for (int p = 0; p < 10; p++) begin
            write_reg(REG_EPS, eps_list[p]);
            write_reg(REG_MODE, mode_list[p]);
            no_gaps = (p == 4);
            repeat (38) send_voxel(rand_voxel());
            drain();
            no_gaps = 0;
        end

        $display("Sent %0d voxels over all eight grouping modes and eps from 1 to 65535;",
                 voxels_sent);
        $display("%0d weight results checked, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
